// File: rtl/crcbu_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 byte unit package
// Shared types, register codes, reset values and the byte fold function.
// ----------------------------------------------------------------------------
package crcbu_pkg;

    localparam int unsigned CRC_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IX_W = 2;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;
    localparam logic             REV_RESET  = 1'b1;

    typedef enum logic [0:0] {
        OP_RESTART = 1'b0,
        OP_ABSORB  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_POLY   = 2'd0,
        REG_INIT   = 2'd1,
        REG_REV_IN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_opcode           opcode;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] init_value;
        logic             reverse_input;
    } t_cfg;

    function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

    // Eight MSB-first shift steps of the polynomial after the byte is
    // folded into the top of the CRC.
    function automatic logic [CRC_W-1:0] absorb_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/crcbu_cfg.sv
// ----------------------------------------------------------------------------
// CRC-32 byte unit configuration registers
// Holds polynomial, init value and the input byte reversal flag.
// ----------------------------------------------------------------------------
module crcbu_cfg
    import crcbu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CRC_W-1:0]    i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_POLY:   n_cfg.polynomial    = i_cfg_data;
                REG_INIT:   n_cfg.init_value    = i_cfg_data;
                REG_REV_IN: n_cfg.reverse_input = i_cfg_data[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polynomial    <= POLY_RESET;
            r_cfg.init_value    <= INIT_RESET;
            r_cfg.reverse_input <= REV_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/crcbu_in_stage.sv
// ----------------------------------------------------------------------------
// CRC-32 byte unit input register
// Captures one request per cycle while the core keeps taking them, and holds each until the core takes it.
// ----------------------------------------------------------------------------
module crcbu_in_stage
    import crcbu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tuser,   // [0] opcode
    input  logic              i_take,
    output logic              o_vld,
    output t_in_item          o_item
);

    logic     r_vld;
    t_in_item r_item;

    assign s_axis_tready = !r_vld || i_take;
    assign o_vld         = r_vld;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.opcode    <= t_opcode'(s_axis_tuser);
            r_item.data_byte <= s_axis_tdata;
        end
    end

endmodule

// File: rtl/crcbu_core.sv
// ----------------------------------------------------------------------------
// CRC-32 byte unit core
// Updates the running CRC from the input register; the CRC register is
// also the result register shown on the output stream.
// ----------------------------------------------------------------------------
module crcbu_core
    import crcbu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_vld,
    input  t_in_item         i_item,
    output logic             o_take,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [CRC_W-1:0] m_axis_tdata   // [31:0] crc_value
);

    logic              r_out_vld;
    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  n_crc;
    logic [BYTE_W-1:0] in_byte;
    logic              advance;

    // The result slot frees up when it is empty or being read this cycle.
    assign advance       = !r_out_vld || m_axis_tready;
    assign o_take        = advance;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_crc;

    assign in_byte = i_cfg.reverse_input ? flip_byte(i_item.data_byte) : i_item.data_byte;

    always_comb begin
        unique case (i_item.opcode)
            OP_RESTART: n_crc = i_cfg.init_value;
            OP_ABSORB:  n_crc = absorb_byte(r_crc, in_byte, i_cfg.polynomial);
            default:    n_crc = r_crc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_crc     <= INIT_RESET;
        end else if (advance) begin
            r_out_vld <= i_vld;
            if (i_vld) begin
                r_crc <= n_crc;
            end
        end
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> $stable(r_crc))
        else $error("running CRC changed while its result was stalled");

    a_restart_loads_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && i_vld && i_item.opcode == OP_RESTART) |=>
            (r_crc == $past(i_cfg.init_value) && r_out_vld))
        else $error("restart did not load the init value");

    a_no_take_without_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance) |-> (r_out_vld && !m_axis_tready))
        else $error("core stalled with a free result slot");

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !i_vld) |=> !r_out_vld)
        else $error("result shown without an input request");

endmodule

// File: rtl/crc32_byte_unit_top.sv
// Path: an accepted request is held in the input register, then folded into the
// running CRC register, which drives the output stream.
// Throughput: one byte or restart per clock while the output is not stalled; the
// eight-step polynomial fold on the running CRC register is combinational.
// Reset (synchronous, active low) sets polynomial 0x04C11DB7, init value and
// running CRC to all ones, byte reversal on, and empties both registers.
// ----------------------------------------------------------------------------
// CRC-32 byte unit top level
// Stream-fed CRC-32 data register with a register write port.
// ----------------------------------------------------------------------------
module crc32_byte_unit_top
    import crcbu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tuser,   // [0] opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [CRC_W-1:0]    m_axis_tdata,   // [31:0] crc_value
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CRC_W-1:0]    i_cfg_data
);

    t_cfg     cfg;
    t_in_item item;
    logic     item_vld;
    logic     take;

    crcbu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crcbu_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (take),
        .o_vld         (item_vld),
        .o_item        (item)
    );

    crcbu_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_vld         (item_vld),
        .i_item        (item),
        .o_take        (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
